/* rtl/ple_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_pkg
// field widths, action codes and status codes for the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

  // fixed field widths of the transaction ports
  localparam int unsigned ACTION_W = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned PAY_W    = 32;
  localparam int unsigned STATUS_W = 2;

  // action codes
  localparam logic [ACTION_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_REMOVE = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_MODIFY = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_FIND   = 3'd4;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

endpackage
`default_nettype wire

/* rtl/ple_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ple_ram
// simple dual-port entry memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module ple_ram #(
  parameter int unsigned WORDS  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 64
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [DATA_W-1:0] wdata_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [WORDS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* rtl/positional_list_engine.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of key/payload entries with 1-based positions; insert, remove,
// modify, read and find-by-key, all entries held in one synchronous memory
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// --------  ---------  --------------------------  ---------------------------
// command   in         start_i high, busy_o low    action_i, position_i,
//                                                  entry_key_i, entry_payload_i
// result    out        done_o high for one cycle   status_o, found_position_o,
//                                                  out_key_o, out_payload_o,
//                                                  entry_count_o
//
// every accepted transaction gives exactly one result
// modify, append, remove of the last entry, errors and unused actions: result in the cycle after accept
// read: one memory read, taken in S_READ and then registered onto the result
// insert with shift: entries move up in S_SHIFT, then S_PLACE writes the entry;
//   remove with shift: entries move down in S_SHIFT; find scans to a hit or the
//   list end; one entry moves or is compared per cycle through the read port
// rst_ni clears the count and control; the memory holds no reset value and
//   is never read below an unwritten entry, so no clearing pass is needed
// the receiver cannot stall: results are presented once on done_o
//
module positional_list_engine
  import ple_pkg::*;
#(
  parameter int unsigned DEPTH        = 16,
  parameter int unsigned KEY_BITS     = 32,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [ACTION_W-1:0] action_i,
  input  wire logic [POS_W-1:0]    position_i,
  input  wire logic [KEY_W-1:0]    entry_key_i,
  input  wire logic [PAY_W-1:0]    entry_payload_i,
  output logic                     done_o,
  output logic [STATUS_W-1:0]      status_o,
  output logic [POS_W-1:0]         found_position_o,
  output logic [KEY_W-1:0]         out_key_o,
  output logic [PAY_W-1:0]         out_payload_o,
  output logic [POS_W-1:0]         entry_count_o
);

  localparam int unsigned AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int unsigned DATA_W = KEY_BITS + PAYLOAD_BITS;

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SHIFT = 3'd1;
  localparam logic [2:0] S_PLACE = 3'd2;
  localparam logic [2:0] S_FIND  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  logic [2:0]              state_q, state_d;
  logic [CNT_W-1:0]        count_q, count_d;
  logic [CNT_W-1:0]        idx_q, idx_d;       // next address to read
  logic [CNT_W-1:0]        end_q, end_d;       // last address to read
  logic [CNT_W-1:0]        wr_q, wr_d;         // target of the data in flight
  logic                    issue_q, issue_d;   // a read is still to be issued
  logic                    pend_q, pend_d;     // read data arrives this cycle
  logic                    up_q, up_d;         // shift direction: insert
  logic [CNT_W-1:0]        pos_q, pos_d;       // zero-based insert slot
  logic [KEY_BITS-1:0]     key_q, key_d;
  logic [PAYLOAD_BITS-1:0] pay_q, pay_d;

  logic                    done_q, done_d;
  logic [STATUS_W-1:0]     status_q, status_d;
  logic [POS_W-1:0]        fpos_q, fpos_d;
  logic [KEY_W-1:0]        okey_q, okey_d;
  logic [PAY_W-1:0]        opay_q, opay_d;

  // memory port
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DATA_W-1:0]       ram_wdata;
  logic [AW-1:0]           ram_raddr;
  logic [DATA_W-1:0]       ram_rdata;
  logic [KEY_BITS-1:0]     rd_key;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  // command decode
  logic                    accept;
  logic [CMP_W-1:0]        pos_ext, cnt_ext;
  logic [CNT_W-1:0]        pos_m1;
  logic                    pos_in_list, pos_ins_ok, list_full;
  logic [KEY_BITS-1:0]     in_key;
  logic [PAYLOAD_BITS-1:0] in_pay;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  assign pos_ext     = CMP_W'(position_i);
  assign cnt_ext     = CMP_W'(count_q);
  assign pos_m1      = CNT_W'(pos_ext - CMP_W'(1));
  assign pos_in_list = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign pos_ins_ok  = (pos_ext != '0) && (pos_ext <= cnt_ext + CMP_W'(1));
  assign list_full   = (cnt_ext == CMP_W'(DEPTH));

  assign in_key = KEY_BITS'(entry_key_i);
  assign in_pay = PAYLOAD_BITS'(entry_payload_i);

  assign rd_key = ram_rdata[DATA_W-1 -: KEY_BITS];
  assign rd_pay = ram_rdata[PAYLOAD_BITS-1:0];

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    idx_d    = idx_q;
    end_d    = end_q;
    wr_d     = wr_q;
    issue_d  = issue_q;
    pend_d   = 1'b0;
    up_d     = up_q;
    pos_d    = pos_q;
    key_d    = key_q;
    pay_d    = pay_q;

    done_d   = 1'b0;
    status_d = status_q;
    fpos_d   = fpos_q;
    okey_d   = okey_q;
    opay_d   = opay_q;

    ram_we    = 1'b0;
    ram_waddr = idx_q[AW-1:0];
    ram_wdata = {key_q, pay_q};
    ram_raddr = idx_q[AW-1:0];

    unique case (state_q)
      S_IDLE: begin
        ram_raddr = pos_m1[AW-1:0];
        if (accept) begin
          // default result: ok, data fields zero, count unchanged
          done_d   = 1'b1;
          status_d = ST_OK;
          fpos_d   = '0;
          okey_d   = '0;
          opay_d   = '0;
          key_d    = in_key;
          pay_d    = in_pay;
          pos_d    = pos_m1;
          case (action_i)
            ACT_INSERT: begin
              if (!pos_ins_ok) begin
                status_d = ST_RANGE;
              end else if (list_full) begin
                status_d = ST_FULL;
              end else if (pos_ext == cnt_ext + CMP_W'(1)) begin
                // append: single write, no shift
                ram_we    = 1'b1;
                ram_waddr = pos_m1[AW-1:0];
                ram_wdata = {in_key, in_pay};
                count_d   = count_q + CNT_W'(1);
              end else begin
                // move entries count-1 down to pos-1 up by one slot
                done_d  = 1'b0;
                up_d    = 1'b1;
                idx_d   = count_q - CNT_W'(1);
                end_d   = pos_m1;
                issue_d = 1'b1;
                state_d = S_SHIFT;
              end
            end
            ACT_REMOVE: begin
              if (!pos_in_list) begin
                status_d = ST_RANGE;
              end else if (pos_ext == cnt_ext) begin
                // last entry: nothing to move
                count_d = count_q - CNT_W'(1);
              end else begin
                // move entries pos..count-1 down by one slot
                done_d  = 1'b0;
                up_d    = 1'b0;
                idx_d   = CNT_W'(position_i);
                end_d   = count_q - CNT_W'(1);
                issue_d = 1'b1;
                state_d = S_SHIFT;
              end
            end
            ACT_MODIFY: begin
              if (!pos_in_list) begin
                status_d = ST_RANGE;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = pos_m1[AW-1:0];
                ram_wdata = {in_key, in_pay};
              end
            end
            ACT_READ: begin
              if (!pos_in_list) begin
                status_d = ST_RANGE;
              end else begin
                // read issued on ram_raddr this cycle
                done_d  = 1'b0;
                state_d = S_READ;
              end
            end
            ACT_FIND: begin
              if (count_q == '0) begin
                status_d = ST_NOTFOUND;
              end else begin
                done_d  = 1'b0;
                idx_d   = '0;
                end_d   = count_q - CNT_W'(1);
                issue_d = 1'b1;
                state_d = S_FIND;
              end
            end
            default: begin
              // unused action: no change, plain ok result
            end
          endcase
        end
      end

      S_SHIFT: begin
        // read slot idx while the slot read last cycle is written back
        if (pend_q) begin
          ram_we    = 1'b1;
          ram_waddr = wr_q[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (issue_q) begin
          pend_d  = 1'b1;
          wr_d    = up_q ? idx_q + CNT_W'(1) : idx_q - CNT_W'(1);
          idx_d   = up_q ? idx_q - CNT_W'(1) : idx_q + CNT_W'(1);
          issue_d = (idx_q != end_q);
        end else if (pend_q) begin
          // last move written this cycle
          if (up_q) begin
            state_d = S_PLACE;
          end else begin
            count_d  = count_q - CNT_W'(1);
            done_d   = 1'b1;
            state_d  = S_IDLE;
          end
        end
      end

      S_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = pos_q[AW-1:0];
        ram_wdata = {key_q, pay_q};
        count_d   = count_q + CNT_W'(1);
        done_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_FIND: begin
        if (issue_q) begin
          pend_d  = 1'b1;
          wr_d    = idx_q;
          idx_d   = idx_q + CNT_W'(1);
          issue_d = (idx_q != end_q);
        end
        if (pend_q && (rd_key == key_q)) begin
          // first match wins, any read in flight is dropped
          pend_d   = 1'b0;
          issue_d  = 1'b0;
          status_d = ST_OK;
          fpos_d   = POS_W'(wr_q + CNT_W'(1));
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end else if (pend_q && !issue_q) begin
          status_d = ST_NOTFOUND;
          done_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_READ: begin
        okey_d  = KEY_W'(rd_key);
        opay_d  = PAY_W'(rd_pay);
        done_d  = 1'b1;
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      issue_q <= 1'b0;
      pend_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      pend_q  <= pend_d;
      done_q  <= done_d;
    end
  end

  // payload and pointer registers, no reset needed
  always_ff @(posedge clk_i) begin
    idx_q    <= idx_d;
    end_q    <= end_d;
    wr_q     <= wr_d;
    up_q     <= up_d;
    pos_q    <= pos_d;
    key_q    <= key_d;
    pay_q    <= pay_d;
    status_q <= status_d;
    fpos_q   <= fpos_d;
    okey_q   <= okey_d;
    opay_q   <= opay_d;
  end

  ple_ram #(
    .WORDS  (DEPTH),
    .ADDR_W (AW),
    .DATA_W (DATA_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign done_o           = done_q;
  assign status_o         = status_q;
  assign found_position_o = fpos_q;
  assign out_key_o        = okey_q;
  assign out_payload_o    = opay_q;
  assign entry_count_o    = POS_W'(count_q);

endmodule
`default_nettype wire
